/* sv/ctbp_pkg.sv */
// Shared types and constants of the combining-tree barrier pool.
`default_nettype none
package ctbp_pkg;

  // Defaults of the top-level parameters.
  localparam int DEF_POOL_TREES = 16;
  localparam int DEF_MAX_LEAVES = 64;

  // Fixed widths of the request and register fields.
  localparam int FUNC_W   = 2;
  localparam int TREE_W   = 4;
  localparam int LEAF_W   = 6;
  localparam int LC_W     = 7;
  localparam int NODE_W   = 8;   // leaf index plus leaf count minus one fits here
  localparam int TREE_X_W = 9;   // wide enough to compare against any pool size

  localparam logic [LC_W-1:0] LC_RESET = 7'd64;

  // Register index, taken from the word address.
  localparam logic CFG_IDX_LEAF_COUNT = 1'b0;

  typedef enum logic [FUNC_W-1:0] {
    FN_ALLOC  = 2'd0,
    FN_ARRIVE = 2'd1,
    FN_FREE   = 2'd2,
    FN_NOP    = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ALLOC_WAIT,
    ST_ARR_LOAD,
    ST_CLIMB,
    ST_ARR_WB,
    ST_RESP
  } state_t;

  // Commands to the arrival flag store.
  typedef struct packed {
    logic rd;
    logic wr;
    logic clr;
  } flag_cmd_t;

endpackage
`default_nettype wire

/* sv/combining_tree_barrier_pool.sv */
// Top level of the combining-tree barrier pool: request sequencer, free list and climb unit.
// One request is handled at a time: the next is accepted in the cycle after the result of the
// last one loads into the output register. The climb loop through the shared adder sets how
// long an arrive takes.
// Resets: synchronous, active high; leaf_count goes to 64, all trees free in order, flags clear.
`default_nettype none
module combining_tree_barrier_pool #(
  parameter int POOL_TREES = ctbp_pkg::DEF_POOL_TREES,
  parameter int MAX_LEAVES = ctbp_pkg::DEF_MAX_LEAVES
) (
  input  wire         clk,
  input  wire         rst,
  // Request stream. tdata from bit 0: func[1:0], tree_id[5:2], leaf_index[11:6], zero pad.
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [15:0] s_tdata,
  // Result stream. tdata from bit 0: status[0], granted_tree[4:1], last_arrival[5], pad.
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [7:0]  m_tdata,
  // Configuration port.
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ctbp_pkg::*;

  // The leaf count register is 7 bits, so no tree ever uses more than 127 leaves.
  localparam int LMAX  = (MAX_LEAVES < 127) ? MAX_LEAVES : 127;
  localparam int NODES = (LMAX > 1) ? LMAX - 1 : 1;
  localparam int FW    = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int TW    = (POOL_TREES > 1) ? $clog2(POOL_TREES) : 1;
  localparam int HW    = $clog2(POOL_TREES + 1);
  localparam logic [LC_W-1:0]     LMAX_C = LC_W'(LMAX);
  localparam logic [TREE_X_W-1:0] POOL_C = TREE_X_W'(POOL_TREES);

  // Effective leaf count minus one: zero counts as one leaf, large values saturate.
  function automatic logic [LC_W-1:0] span_of(input logic [LC_W-1:0] v);
    logic [LC_W-1:0] l;
    l = (v == '0) ? LC_W'(1) : v;
    if (l > LMAX_C) begin
      l = LMAX_C;
    end
    return l - LC_W'(1);
  endfunction

  state_t state, state_next;

  // Latched request.
  func_t             func_q;
  logic [TREE_W-1:0] tree_q;
  logic [LEAF_W-1:0] leaf_q;

  // Configuration.
  logic [LC_W-1:0] leaf_count;
  logic [LC_W-1:0] span_m1;
  logic            cfg_wr;

  // Free list.
  logic [HW-1:0]         head;
  logic [HW-1:0]         link_mem [POOL_TREES];
  logic [POOL_TREES-1:0] link_valid;
  logic [HW-1:0]         link_rd_q;
  logic                  link_rd_vq;
  logic                  link_rd;
  logic                  link_wr;

  // Climb datapath.
  logic [NODE_W-1:0] node;
  logic [NODES-1:0]  row;
  logic [NODES-1:0]  flag_rdata;
  flag_cmd_t         flag_cmd;
  logic [NODE_W-1:0] alu_a, alu_b, alu_sum;
  logic [NODE_W-1:0] parent;
  logic [FW-1:0]     pidx;
  logic              was_set;
  logic              at_root;

  // Result.
  logic              res_status;
  logic [TREE_W-1:0] res_granted;
  logic              res_last;
  logic              out_free;
  logic              out_load;

  // Decode helpers.
  logic [TREE_X_W-1:0] tree_ext;
  logic [TREE_X_W-1:0] head_ext;
  logic [TW-1:0]       tree_idx;
  logic [TW-1:0]       head_idx;
  logic                tree_ok;
  logic                leaf_ok;
  logic                pool_empty;
  logic                in_accept;

  assign in_accept  = s_tvalid && s_tready;
  assign tree_ext   = TREE_X_W'(tree_q);
  assign head_ext   = TREE_X_W'(head);
  assign tree_idx   = tree_ext[TW-1:0];
  assign head_idx   = head_ext[TW-1:0];
  assign tree_ok    = tree_ext < POOL_C;
  assign leaf_ok    = LC_W'(leaf_q) <= span_m1;
  assign pool_empty = head_ext >= POOL_C;

  // The shared adder: it forms the starting leaf node, then takes one off per level.
  always_comb begin
    if (state == ST_DECODE) begin
      alu_a = NODE_W'(leaf_q);
      alu_b = NODE_W'(span_m1);
    end else begin
      alu_a = node;
      alu_b = '1;
    end
  end
  assign alu_sum = alu_a + alu_b;
  assign parent  = {1'b0, alu_sum[NODE_W-1:1]};
  assign pidx    = parent[FW-1:0];
  assign was_set = row[pidx];
  assign at_root = node == '0;

  // Configuration port: writes land at the access phase, reads are always ready.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == CFG_IDX_LEAF_COUNT) ? 32'(leaf_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      leaf_count <= LC_RESET;
      span_m1    <= span_of(LC_RESET);
    end else if (cfg_wr && paddr[2] == CFG_IDX_LEAF_COUNT) begin
      leaf_count <= pwdata[LC_W-1:0];
      span_m1    <= span_of(pwdata[LC_W-1:0]);
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (func_q)
          FN_ALLOC:  state_next = pool_empty ? ST_RESP : ST_ALLOC_WAIT;
          FN_ARRIVE: state_next = (tree_ok && leaf_ok) ? ST_ARR_LOAD : ST_RESP;
          FN_FREE:   state_next = ST_RESP;
          default:   state_next = ST_RESP;
        endcase
      end
      ST_ALLOC_WAIT: state_next = ST_RESP;
      ST_ARR_LOAD:   state_next = ST_CLIMB;
      ST_CLIMB: begin
        if (at_root || !was_set) begin
          state_next = ST_ARR_WB;
        end
      end
      ST_ARR_WB: state_next = ST_RESP;
      ST_RESP: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  assign out_free = !m_tvalid || m_tready;
  always_comb begin
    s_tready = 1'b0;
    flag_cmd = '0;
    link_rd  = 1'b0;
    link_wr  = 1'b0;
    out_load = 1'b0;
    unique case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_DECODE: begin
        if (func_q == FN_ALLOC && !pool_empty) begin
          link_rd = 1'b1;
        end
        if (func_q == FN_ARRIVE && tree_ok && leaf_ok) begin
          flag_cmd.rd = 1'b1;
        end
        if (func_q == FN_FREE && tree_ok) begin
          flag_cmd.clr = 1'b1;
          link_wr      = 1'b1;
        end
      end
      ST_ARR_WB: flag_cmd.wr = 1'b1;
      ST_RESP:   out_load = out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Request capture and result fields.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      func_q      <= func_t'(s_tdata[1:0]);
      tree_q      <= s_tdata[5:2];
      leaf_q      <= s_tdata[11:6];
      res_status  <= 1'b0;
      res_granted <= '0;
      res_last    <= 1'b0;
    end
    if (state == ST_DECODE && func_q == FN_ALLOC) begin
      if (pool_empty) begin
        res_status <= 1'b1;
      end else begin
        res_granted <= head_ext[TREE_W-1:0];
      end
    end
    if (state == ST_CLIMB && at_root) begin
      res_last <= 1'b1;
    end
  end

  // Climb: fetch the tree's flag row, walk toward the root setting flags, write it back.
  always_ff @(posedge clk) begin
    if (state == ST_DECODE) begin
      node <= alu_sum;
    end
    if (state == ST_ARR_LOAD) begin
      row <= flag_rdata;
    end
    if (state == ST_CLIMB && !at_root) begin
      row[pidx] <= 1'b1;
      node      <= parent;
    end
  end

  ctbp_flag_store #(
    .TREES (POOL_TREES),
    .ROW_W (NODES),
    .AW    (TW)
  ) u_flags (
    .clk   (clk),
    .rst   (rst),
    .cmd   (flag_cmd),
    .addr  (tree_idx),
    .wdata (row),
    .rdata (flag_rdata)
  );

  // Free list: a link that was never written reads as the next tree in order.
  always_ff @(posedge clk) begin
    if (link_wr) begin
      link_mem[tree_idx] <= head;
    end
    if (link_rd) begin
      link_rd_q  <= link_mem[head_idx];
      link_rd_vq <= link_valid[head_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_valid <= '0;
      head       <= '0;
    end else begin
      if (link_wr) begin
        link_valid[tree_idx] <= 1'b1;
        head                 <= tree_ext[HW-1:0];
      end else if (state == ST_ALLOC_WAIT) begin
        head <= link_rd_vq ? link_rd_q : head + HW'(1);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {2'b00, res_last, res_granted, res_status};
    end
  end

endmodule
`default_nettype wire

/* sv/ctbp_flag_store.sv */
// Arrival flag rows, one row per tree, with per-row valid bits for reset and free.
`default_nettype none
module ctbp_flag_store #(
  parameter int TREES = 16,
  parameter int ROW_W = 63,
  parameter int AW    = 4
) (
  input  wire                 clk,
  input  wire                 rst,
  input  ctbp_pkg::flag_cmd_t cmd,
  input  wire  [AW-1:0]       addr,
  input  wire  [ROW_W-1:0]    wdata,
  output logic [ROW_W-1:0]    rdata
);
  import ctbp_pkg::*;

  logic [ROW_W-1:0] mem [TREES];
  logic [TREES-1:0] row_valid;
  logic [ROW_W-1:0] rd_q;
  logic             rd_valid_q;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[addr] <= wdata;
    end
    if (cmd.rd) begin
      rd_q       <= mem[addr];
      rd_valid_q <= row_valid[addr];
    end
  end

  // A row that is not valid reads as all clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (cmd.wr) begin
      row_valid[addr] <= 1'b1;
    end else if (cmd.clr) begin
      row_valid[addr] <= 1'b0;
    end
  end

  assign rdata = rd_valid_q ? rd_q : '0;

endmodule
`default_nettype wire
